@@ rtl/b64e_pkg.sv @@
// shared types and constants for the base64 stream encoder
// job record passed from front to back, sextet to ascii mapping
// no dependencies
package b64e_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;
   localparam int         MAX_SYMS = 4;

   // one output symbol: either a padding mark or a six-bit value
   typedef struct packed {
      logic       pad;
      logic [5:0] sextet;
   } sym_type;

   // work for one request byte
   typedef struct packed {
      sym_type [MAX_SYMS-1:0] syms;
      logic    [1:0]          last_idx;
      logic                   msg_end;
   } job_type;

   typedef enum logic [1:0] {
      PHASE_ZERO = 2'd0,
      PHASE_ONE  = 2'd1,
      PHASE_TWO  = 2'd2,
      PHASE_BAD  = 2'd3
   } phase_type;

   function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
      logic [7:0] ch;
      if (v < 6'd26) begin
         ch = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         ch = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         ch = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

endpackage

@@ rtl/b64e_front.sv @@
// front end: accepts request bytes, tracks group phase and leftover bits
// builds one job per byte with its sextets and padding; uses b64e_pkg
module b64e_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic             in_end,
   input  logic             q_full,
   output logic             in_ready,
   output logic             q_push,
   output b64e_pkg::job_type q_job
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          spare_ff, spare_in;

   assign in_ready = !q_full;
   assign q_push   = in_valid && !q_full;

   always_comb begin
      b64e_pkg::job_type job;
      b64e_pkg::phase_type np;
      logic [3:0]          ns;
      logic [1:0]          n;
      job = '0;
      np  = b64e_pkg::PHASE_ZERO;
      ns  = 4'd0;
      n   = 2'd0;
      unique case (phase_ff)
         b64e_pkg::PHASE_ONE: begin
            job.syms[0] = '{pad: 1'b0, sextet: {spare_ff[1:0], in_byte[7:4]}};
            ns = in_byte[3:0];
            np = b64e_pkg::PHASE_TWO;
            n  = 2'd1;
         end
         b64e_pkg::PHASE_TWO: begin
            job.syms[0] = '{pad: 1'b0, sextet: {spare_ff, in_byte[7:6]}};
            job.syms[1] = '{pad: 1'b0, sextet: in_byte[5:0]};
            ns = 4'd0;
            np = b64e_pkg::PHASE_ZERO;
            n  = 2'd2;
         end
         default: begin
            job.syms[0] = '{pad: 1'b0, sextet: in_byte[7:2]};
            ns = {2'b00, in_byte[1:0]};
            np = b64e_pkg::PHASE_ONE;
            n  = 2'd1;
         end
      endcase
      if (in_end) begin
         if (np == b64e_pkg::PHASE_ONE) begin
            job.syms[1] = '{pad: 1'b0, sextet: {ns[1:0], 4'b0000}};
            job.syms[2] = '{pad: 1'b1, sextet: 6'd0};
            job.syms[3] = '{pad: 1'b1, sextet: 6'd0};
            n = 2'd0;
         end else if (np == b64e_pkg::PHASE_TWO) begin
            job.syms[1] = '{pad: 1'b0, sextet: {ns, 2'b00}};
            job.syms[2] = '{pad: 1'b1, sextet: 6'd0};
            n = 2'd3;
         end
         np = b64e_pkg::PHASE_ZERO;
         ns = 4'd0;
      end
      // n wraps to zero for four symbols
      job.last_idx = n - 2'd1;
      job.msg_end  = in_end;
      q_job        = job;
      phase_in     = q_push ? np : phase_ff;
      spare_in     = q_push ? ns : spare_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PHASE_ZERO;
         spare_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         spare_ff <= spare_in;
      end
   end

endmodule

@@ rtl/b64e_fifo.sv @@
// short job queue between front and back ends
// register array with read and write pointers; uses b64e_pkg
module b64e_fifo #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64e_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output b64e_pkg::job_type head_job
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   b64e_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full      = count_ff == CW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_job  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/b64e_back.sv @@
// back end: holds one job and sends its characters one per cycle while out_ready is high
// maps sextets to ascii and flags run and message ends; uses b64e_pkg
module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  b64e_pkg::job_type q_job,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_char,
   output logic              out_run_last,
   output logic              out_text_end
);

   logic              busy_ff, busy_in;
   b64e_pkg::job_type job_ff, job_in;
   logic [1:0]        idx_ff, idx_in;
   logic              fire, at_last;
   b64e_pkg::sym_type cur;

   assign cur          = job_ff.syms[idx_ff];
   assign at_last      = idx_ff == job_ff.last_idx;
   assign fire         = busy_ff && out_ready;
   assign out_valid    = busy_ff;
   assign out_char     = cur.pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_to_ascii(cur.sextet);
   assign out_run_last = at_last;
   assign out_text_end = at_last && job_ff.msg_end;
   assign q_pop        = q_not_empty && (!busy_ff || (fire && at_last));

   always_comb begin
      busy_in = busy_ff;
      job_in  = job_ff;
      idx_in  = idx_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         job_in  = q_job;
         idx_in  = 2'd0;
      end else if (fire) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   // message end only on the last character of a run
   a_end_on_run_last: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_text_end |-> out_run_last)
      else $error("text end without run last");

   // a held character advances only after it was taken
   a_idx_steps: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !out_ready |=> busy_ff && $stable(idx_ff))
      else $error("character index moved while stalled");

   // the queue is read only when the current job is done
   a_pop_when_done: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !busy_ff || (out_ready && at_last))
      else $error("job loaded over an unfinished one");

endmodule

@@ rtl/base64_stream_encoder_core.sv @@
// base64 stream encoder, standard alphabet with '=' padding. each request
// carries one message byte, tlast marking the final byte of the message.
// the response stream gives one character per cycle while a job is held and
// rsp_tready is high: a byte yields one or two characters, the final byte
// up to four. the back end serializer sets the rate, one character per clock
// unless stalled, four characters per three bytes with the last group padded
// to four. the front end takes a byte every cycle while the job queue has room.
// top level; uses b64e_pkg, b64e_front, b64e_fifo, b64e_back
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,   // message_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // text_char
   output logic       rsp_tuser,   // run_last
   output logic       rsp_tlast    // text_end
);

   logic              q_full, q_push, q_pop, q_not_empty;
   b64e_pkg::job_type push_job, head_job;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_byte  (req_tdata),
      .in_end   (req_tlast),
      .q_full   (q_full),
      .in_ready (req_tready),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   b64e_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_job        (head_job),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_char     (rsp_tdata),
      .out_run_last (rsp_tuser),
      .out_text_end (rsp_tlast)
   );

endmodule

@@ tb/sv/b64e_checker.sv @@
// checker for the base64 stream encoder: watches request and response channels
// predicts the character stream from the request bytes and compares each field
// depends on b64e_pkg for the phase type and the padding character
`timescale 1ns / 1ps

module b64e_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tuser,
   input  logic       rsp_tlast,
   output int         mismatch_count,
   output int         chars_pending,
   output int         chars_checked
);

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] text_char;
      logic       run_last;
      logic       text_end;
   } text_item_type;

   text_item_type       expected_text[$];
   b64e_pkg::phase_type group_phase;
   logic [3:0]          spare_bits;

   function automatic logic [7:0] base64_char(input logic [5:0] sextet);
      return ALPHABET[8*(63 - int'(sextet)) +: 8];
   endfunction

   task automatic encode_byte(input logic [7:0] data_byte, input logic message_end);
      logic [7:0] chars[$];
      text_item_type item;
      case (group_phase)
         b64e_pkg::PHASE_ONE: begin
            chars = {chars, base64_char({spare_bits[1:0], data_byte[7:4]})};
            spare_bits  = data_byte[3:0];
            group_phase = b64e_pkg::PHASE_TWO;
         end
         b64e_pkg::PHASE_TWO: begin
            chars = {chars, base64_char({spare_bits, data_byte[7:6]})};
            chars = {chars, base64_char(data_byte[5:0])};
            spare_bits  = 4'd0;
            group_phase = b64e_pkg::PHASE_ZERO;
         end
         default: begin
            chars = {chars, base64_char(data_byte[7:2])};
            spare_bits  = {2'b00, data_byte[1:0]};
            group_phase = b64e_pkg::PHASE_ONE;
         end
      endcase
      if (message_end) begin
         // flush the partial group and pad to four characters
         if (group_phase == b64e_pkg::PHASE_ONE) begin
            chars = {chars, base64_char({spare_bits[1:0], 4'd0})};
            chars = {chars, b64e_pkg::PAD_CHAR};
            chars = {chars, b64e_pkg::PAD_CHAR};
         end else if (group_phase == b64e_pkg::PHASE_TWO) begin
            chars = {chars, base64_char({spare_bits, 2'd0})};
            chars = {chars, b64e_pkg::PAD_CHAR};
         end
         group_phase = b64e_pkg::PHASE_ZERO;
         spare_bits  = 4'd0;
      end
      foreach (chars[i]) begin
         item.text_char = chars[i];
         item.run_last  = (i == chars.size() - 1);
         item.text_end  = item.run_last && message_end;
         expected_text = {expected_text, item};
      end
   endtask

   task automatic check_char();
      text_item_type want;
      if (expected_text.size() == 0) begin
         $error("unexpected character %h with no request pending", rsp_tdata);
         mismatch_count++;
      end else begin
         want = expected_text.pop_front();
         if (rsp_tdata !== want.text_char) begin
            $error("text_char: expected %h, got %h", want.text_char, rsp_tdata);
            mismatch_count++;
         end
         if (rsp_tuser !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, rsp_tuser);
            mismatch_count++;
         end
         if (rsp_tlast !== want.text_end) begin
            $error("text_end: expected %b, got %b", want.text_end, rsp_tlast);
            mismatch_count++;
         end
      end
      chars_checked++;
   endtask

   initial begin
      mismatch_count = 0;
      chars_checked  = 0;
      chars_pending  = 0;
      group_phase    = b64e_pkg::PHASE_ZERO;
      spare_bits     = 4'd0;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_text.delete();
         group_phase = b64e_pkg::PHASE_ZERO;
         spare_bits  = 4'd0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_char();
         end
      end
      chars_pending = expected_text.size();
   end

endmodule

@@ tb/sv/tb_base64_stream_encoder_core.sv @@
// top of the base64 stream encoder testbench: clock, reset and request stimulus
// directed messages then random ones under three idling mixes; b64e_checker judges
// depends on base64_stream_encoder_core and b64e_checker
`timescale 1ns / 1ps

module tb_base64_stream_encoder_core;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   int mismatch_count;
   int chars_pending;
   int chars_checked;
   int tx_idle_pct = 36;
   int rx_idle_pct = 71;
   int bytes_sent  = 0;
   int messages_sent = 0;

   base64_stream_encoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   b64e_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending),
      .chars_checked  (chars_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic send_byte(input logic [7:0] value, input logic is_last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (is_last) messages_sent++;
   endtask

   // short message, first byte in the highest used bits
   task automatic send_short(input logic [31:0] bytes, input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(bytes[8*(len-1-i) +: 8], i == len - 1);
      end
   endtask

   task automatic send_random_messages(input int byte_budget);
      int len;
      int target;
      target = bytes_sent + byte_budget;
      while (bytes_sent < target) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(6, 1);
         for (int i = 0; i < len; i++) begin
            send_byte($urandom_range(255), i == len - 1);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end of message in every group phase, extreme bytes
      send_short(32'h00, 1);
      send_short(32'hFF, 1);
      send_short(32'h0000, 2);
      send_short(32'hFFFF, 2);
      send_short(32'h4D616E, 3);
      send_short(32'hFBEFBE, 3);
      send_short(32'hFFFFFF, 3);
      send_short(32'h0080017F, 4);

      send_random_messages(155);
      tx_idle_pct = 71;
      rx_idle_pct = 36;
      send_random_messages(155);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_random_messages(155);
      req_tvalid <= 1'b0;

      while (chars_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("encoded %0d bytes in %0d messages, %0d characters checked",
               bytes_sent, messages_sent, chars_checked);
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d characters still expected", chars_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ base64_stream_encoder_core.f @@
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_fifo.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_core.sv
tb/sv/b64e_checker.sv
tb/sv/tb_base64_stream_encoder_core.sv
